[rtl/stereo_match_triangulator_assert.svh]
// Assertion macros for the stereo match triangulator.
`ifndef STEREO_MATCH_TRIANGULATOR_ASSERT_SVH
`define STEREO_MATCH_TRIANGULATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SMT_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("stereo_match_triangulator: check failed");
`define SMT_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("stereo_match_triangulator: check failed");
`else
`define SMT_ASSERT_IMPL(name, pre, post)
`define SMT_ASSERT_NEXT(name, pre, post)
`endif
`endif

[rtl/smt_pkg.sv]
// Shared types and constants of the stereo match triangulator.
package smt_pkg;

  localparam int QDepth = 4;
  localparam int QCntW  = 3;
  localparam int QPtrW  = 2;

  typedef enum logic [2:0] {
    REG_CENTER_X      = 3'd0,
    REG_CENTER_Y      = 3'd1,
    REG_FOCAL_LENGTH  = 3'd2,
    REG_BASELINE      = 3'd3,
    REG_MIN_DISPARITY = 3'd4,
    REG_MAX_ROW_DIFF  = 3'd5
  } smt_reg_t;

  typedef struct packed {
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] focal_length;
    logic [15:0] baseline;
    logic [15:0] min_disparity;
    logic [15:0] max_row_diff;
  } smt_cfg_t;

  typedef struct packed {
    logic        x_neg;
    logic        y_neg;
    logic [16:0] meas_col;
    logic [16:0] meas_row;
    logic [15:0] index;
  } smt_side_t;

  typedef struct packed {
    logic [31:0] prod_z;
    logic [31:0] prod_x;
    logic [32:0] prod_y;
    logic [15:0] disp;
    smt_side_t   side;
  } smt_entry_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             full;
    logic             empty;
  } smt_qstat_t;

  typedef struct packed {
    logic fa_valid;
    logic fa_pass;
  } smt_fstat_t;

endpackage

[rtl/smt_front.sv]
// Front end: takes a keypoint pair, centers it, checks the limits, forms the products.
module smt_front
  import smt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,
  input  smt_cfg_t    cfg,
  input  logic        q_full,
  output logic        push,
  output smt_entry_t  push_data,
  output smt_fstat_t  fstat
);

  logic        fa_valid_r;
  logic [15:0] lc_r, lr_r, rc_r, rr_r, idx_r;
  logic        fa_go;
  logic [16:0] x1, y1, y2, d, dr, x1_neg, dr_neg;
  logic [17:0] ysum, ysum_neg;
  logic [15:0] abs_x1, abs_dr;
  logic [16:0] abs_ysum;
  logic        pass;

  assign fa_go     = !q_full;
  assign in_tready = !fa_valid_r || fa_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_valid_r <= 1'b0;
    end else if (in_tready) begin
      fa_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      lc_r  <= in_tdata[15:0];
      lr_r  <= in_tdata[31:16];
      rc_r  <= in_tdata[47:32];
      rr_r  <= in_tdata[63:48];
      idx_r <= in_tdata[79:64];
    end
  end

  always_comb begin
    x1       = {1'b0, lc_r} - {1'b0, cfg.center_x};
    y1       = {1'b0, lr_r} - {1'b0, cfg.center_y};
    y2       = {1'b0, rr_r} - {1'b0, cfg.center_y};
    d        = {1'b0, lc_r} - {1'b0, rc_r};
    dr       = {1'b0, lr_r} - {1'b0, rr_r};
    ysum     = {y1[16], y1} + {y2[16], y2};
    x1_neg   = 17'd0 - x1;
    dr_neg   = 17'd0 - dr;
    ysum_neg = 18'd0 - ysum;
    abs_x1   = x1[16] ? x1_neg[15:0] : x1[15:0];
    abs_dr   = dr[16] ? dr_neg[15:0] : dr[15:0];
    abs_ysum = ysum[17] ? ysum_neg[16:0] : ysum[16:0];
    // positive disparity above the minimum also keeps the divisor nonzero
    pass = !d[16] && (d[15:0] > cfg.min_disparity) && (abs_dr < cfg.max_row_diff) &&
           (cfg.focal_length != 16'd0) && (cfg.baseline != 16'd0);
  end

  // drop failing pairs as they leave the front register
  assign push = fa_valid_r && fa_go && pass;

  always_comb begin
    push_data.prod_z        = cfg.focal_length * cfg.baseline;
    push_data.prod_x        = abs_x1 * cfg.baseline;
    push_data.prod_y        = abs_ysum * {1'b0, cfg.baseline};
    push_data.disp          = d[15:0];
    push_data.side.x_neg    = x1[16];
    push_data.side.y_neg    = ysum[17];
    push_data.side.meas_col = x1;
    push_data.side.meas_row = y1;
    push_data.side.index    = idx_r;
  end

  assign fstat.fa_valid = fa_valid_r;
  assign fstat.fa_pass  = pass;

endmodule

[rtl/smt_queue.sv]
// Short queue between the front end and the divider back end.
module smt_queue
  import smt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  smt_entry_t push_data,
  input  logic       pop,
  output smt_entry_t head,
  output smt_qstat_t qstat
);

  smt_entry_t       mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign head        = mem_r[rd_ptr_r];
  assign qstat.count = count_r;
  assign qstat.full  = (count_r == QCntW'(QDepth));
  assign qstat.empty = (count_r == '0);

endmodule

[rtl/smt_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module smt_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot
);

  logic [NUM_W-1:0] word_r [NUM_W];
  logic [DEN_W-1:0] rem_r  [NUM_W];
  logic [DEN_W-1:0] den_r  [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [NUM_W-1:0] word_in;
    logic [DEN_W-1:0] rem_in, den_in;
    logic [DEN_W:0]   trial, diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign word_in = num;
      assign rem_in  = '0;
      assign den_in  = den;
    end else begin : g_next
      assign word_in = word_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign den_in  = den_r[i-1];
    end

    assign trial = {rem_in, word_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    // shift the next dividend bit out at the top into the remainder and the quotient bit in at the bottom
    always_ff @(posedge clk) begin
      if (en) begin
        word_r[i] <= {word_in[NUM_W-2:0], ge};
        rem_r[i]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den_r[i]  <= den_in;
      end
    end
  end

  assign quot = word_r[NUM_W-1];

endmodule

[rtl/smt_back.sv]
// Back end: rounded divisions by the disparity, saturation and output register.
module smt_back
  import smt_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  input  smt_entry_t   head,
  input  logic         q_empty,
  output logic         pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata
);

  localparam int MW = 35 + OUT_FRAC_BITS;
  localparam int QW = MW - 13;
  localparam int QX = (QW > 32) ? QW : 32;

  logic            adv;
  logic [MW-1:0]   m_z, m_x, m_y, dsh12, dsh13;
  logic [QW-1:0]   num_z, num_x, num_y, q_z, q_x, q_y;
  logic [QX-1:0]   qz_e, qx_e, qy_e;
  logic            valid_r [QW];
  smt_side_t       side_r  [QW];
  logic            out_valid_r;
  logic [31:0]     pos_x_r, pos_y_r;
  logic [30:0]     pos_z_r;
  logic [16:0]     meas_col_r, meas_row_r;
  logic [15:0]     index_r;

  function automatic logic [31:0] sat_signed(input logic neg, input logic [QX-1:0] mag);
    logic big;
    logic [31:0] low;
    big = |mag[QX-1:31];
    low = {1'b0, mag[30:0]};
    if (neg) begin
      sat_signed = big ? 32'h8000_0000 : 32'd0 - low;
    end else begin
      sat_signed = big ? 32'h7FFF_FFFF : low;
    end
  endfunction

  assign adv = !out_valid_r || out_tready;
  assign pop = adv && !q_empty;

  // rounding folded in: (2n + den) / (2 den), with the power-of-two part as a shift
  always_comb begin
    dsh12 = MW'(head.disp) << 12;
    dsh13 = MW'(head.disp) << 13;
    m_z   = (MW'(head.prod_z) << (OUT_FRAC_BITS + 1)) + dsh12;
    m_x   = (MW'(head.prod_x) << (OUT_FRAC_BITS + 1)) + dsh12;
    m_y   = (MW'(head.prod_y) << (OUT_FRAC_BITS + 1)) + dsh13;
    num_z = QW'(m_z >> 13);
    num_x = QW'(m_x >> 13);
    num_y = QW'(m_y >> 14);
  end

  smt_div #(.NUM_W(QW), .DEN_W(16)) u_div_z (
    .clk(clk), .en(adv), .num(num_z), .den(head.disp), .quot(q_z)
  );
  smt_div #(.NUM_W(QW), .DEN_W(16)) u_div_x (
    .clk(clk), .en(adv), .num(num_x), .den(head.disp), .quot(q_x)
  );
  smt_div #(.NUM_W(QW), .DEN_W(16)) u_div_y (
    .clk(clk), .en(adv), .num(num_y), .den(head.disp), .quot(q_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QW; i++) valid_r[i] <= 1'b0;
    end else if (adv) begin
      valid_r[0] <= !q_empty;
      for (int i = 1; i < QW; i++) valid_r[i] <= valid_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= head.side;
      for (int i = 1; i < QW; i++) side_r[i] <= side_r[i-1];
    end
  end

  assign qz_e = QX'(q_z);
  assign qx_e = QX'(q_x);
  assign qy_e = QX'(q_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= valid_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_x_r    <= sat_signed(side_r[QW-1].x_neg, qx_e);
      pos_y_r    <= sat_signed(side_r[QW-1].y_neg, qy_e);
      pos_z_r    <= (|qz_e[QX-1:31]) ? 31'h7FFF_FFFF : qz_e[30:0];
      meas_col_r <= side_r[QW-1].meas_col;
      meas_row_r <= side_r[QW-1].meas_row;
      index_r    <= side_r[QW-1].index;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, index_r, meas_row_r, meas_col_r, pos_z_r, pos_y_r, pos_x_r};

endmodule

[rtl/stereo_match_triangulator.sv]
// Top level of the stereo match triangulator.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------------
//  in_      | input     | in_tvalid/in_tready   | in_tdata: left/right col/row, left index
//  out_     | output    | out_tvalid/out_tready | out_tdata: pos x/y/z, meas col/row, index
//  cfg_     | input     | cfg_valid/cfg_ready   | cfg_index, cfg_data (16-bit register)
//
// One item per cycle sustained while out_tready stays high. An accepted item passes the front
// register, one queue slot, 22 + OUT_FRAC_BITS pipelined divider stages and the output register
// before it reaches out_tdata with out_tvalid high. Reset (rst_n low, synchronous) empties front,
// queue and pipeline and loads register defaults. An output stall freezes the back
// pipeline; the queue and the front register absorb up to five items before in_tready
// drops. Pairs failing the checks give no item.
module stereo_match_triangulator
  import smt_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // left_col[15:0], left_row[31:16], right_col[47:32], right_row[63:48], left_index[79:64]
  input  logic [79:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[94:64], meas_col[111:95], meas_row[128:112],
  // point_index[144:129], zero fill[151:145]
  output logic [151:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

`include "stereo_match_triangulator_assert.svh"

  smt_cfg_t   cfg_r;
  logic       q_push, q_pop;
  smt_entry_t q_push_data, q_head;
  smt_qstat_t qstat;
  smt_fstat_t fstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x      <= 16'd9715;
      cfg_r.center_y      <= 16'd2963;
      cfg_r.focal_length  <= 16'd11502;
      cfg_r.baseline      <= 16'd2212;
      cfg_r.min_disparity <= 16'd16;
      cfg_r.max_row_diff  <= 16'd160;
    end else if (cfg_valid && cfg_ready) begin
      unique case (smt_reg_t'(cfg_index))
        REG_CENTER_X:      cfg_r.center_x      <= cfg_data;
        REG_CENTER_Y:      cfg_r.center_y      <= cfg_data;
        REG_FOCAL_LENGTH:  cfg_r.focal_length  <= cfg_data;
        REG_BASELINE:      cfg_r.baseline      <= cfg_data;
        REG_MIN_DISPARITY: cfg_r.min_disparity <= cfg_data;
        REG_MAX_ROW_DIFF:  cfg_r.max_row_diff  <= cfg_data;
        default:           cfg_r               <= cfg_r;
      endcase
    end
  end

  smt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg       (cfg_r),
    .q_full    (qstat.full),
    .push      (q_push),
    .push_data (q_push_data),
    .fstat     (fstat)
  );

  smt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .qstat     (qstat)
  );

  smt_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_empty    (qstat.empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `SMT_ASSERT_IMPL(a_queue_bound, 1'b1, qstat.count <= QCntW'(QDepth))
  `SMT_ASSERT_IMPL(a_no_push_when_full, q_push, !qstat.full)
  `SMT_ASSERT_IMPL(a_no_pop_when_empty, q_pop, !qstat.empty)
  `SMT_ASSERT_NEXT(a_front_holds, fstat.fa_valid && qstat.full && !q_pop, fstat.fa_valid)
  `SMT_ASSERT_IMPL(a_push_passes, q_push, fstat.fa_pass)

endmodule
